// ===== hw/rtl/pbu_pkg.sv =====
// ----------------------------------------------------------------------------
// pbu_pkg
// Shared types and constants for the RGB pixel blend unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pbu_pkg;

  // Channel count and packed stream widths
  localparam int NUM_CHAN = 3;
  localparam int PIX_W    = 8;
  localparam int IN_W     = 2 * NUM_CHAN * PIX_W;
  localparam int OUT_W    = NUM_CHAN * PIX_W;

  // Rounded divide by 255: q = ((p + 127) * 131587) >> 25, exact for sums below 132626
  localparam int SUM_W       = 17;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int QUO_W       = 9;
  localparam int RECIP_SHIFT = 25;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 18'd131587;
  localparam logic [SUM_W-1:0]   ROUND_BIAS = 17'd127;

  // Blend mode register codes
  typedef enum logic [1:0] {
    MODE_MULTIPLY = 2'd0,
    MODE_SUBTRACT = 2'd1,
    MODE_SCREEN   = 2'd2,
    MODE_OVERLAY  = 2'd3
  } blend_mode_t;

  // Per-channel result control carried down the pipe
  typedef struct packed {
    logic             sub;   // take the clamped difference
    logic             inv;   // result is 255 minus the quotient
    logic [PIX_W-1:0] diff;  // bottom minus top, clamped at 0
  } chan_ctl_t;

  typedef logic      [NUM_CHAN-1:0][PIX_W-1:0] pix_vec_t;
  typedef logic      [NUM_CHAN-1:0][SUM_W-1:0] sum_vec_t;
  typedef logic      [NUM_CHAN-1:0][QUO_W-1:0] quo_vec_t;
  typedef chan_ctl_t [NUM_CHAN-1:0]            ctl_vec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rgb_pixel_blend_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_pixel_blend_unit
// Per-channel layer blend (multiply, subtract, screen, overlay) of two pixels.
// ----------------------------------------------------------------------------
//
//  channel   | direction | signals                      | payload
//  ----------+-----------+------------------------------+--------------------------
//  s_axis    | in        | tvalid, tready, tdata[47:0]  | top r,g,b / bottom r,g,b
//  m_axis    | out       | tvalid, tready, tdata[23:0]  | blended r,g,b
//  cfg       | in        | valid, ready, data[1:0]      | blend mode
//
//  Four register stages: operand select, 8x8 multiply, reciprocal divide by
//  255, result select. One pixel per cycle sustained while the output is taken;
//  stages two and three each hold a single multiplier per channel.
//  All stages advance together whenever the output register is empty or taken.
//  Reset clears the stage valid bits and sets the mode to multiply.
//  The mode register always accepts a write.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_pixel_blend_unit
  import pbu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // tdata: top_red, top_green, top_blue, bottom_red, bottom_green, bottom_blue
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  // tdata: out_red, out_green, out_blue
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [OUT_W-1:0] m_axis_tdata,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_data
);

  blend_mode_t mode;
  logic        en;
  logic        v1, v2, v3;
  pix_vec_t    top, bottom;
  pix_vec_t    x1, y1;
  logic        dbl1;
  ctl_vec_t    ctl1, ctl2, ctl3;
  sum_vec_t    sum2;
  quo_vec_t    quo3;
  pix_vec_t    res_next;
  logic [NUM_CHAN-1:0] sub3, inv3;

  // Pipeline advance: whole pipe moves when the output slot frees
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  // Unpack input transfer
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      top[c]    = s_axis_tdata[c*PIX_W +: PIX_W];
      bottom[c] = s_axis_tdata[(NUM_CHAN + c)*PIX_W +: PIX_W];
    end
  end

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MULTIPLY;
    end else if (cfg_valid && cfg_ready) begin
      mode <= blend_mode_t'(cfg_data);
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v1            <= s_axis_tvalid;
      v2            <= v1;
      v3            <= v2;
      m_axis_tvalid <= v3;
    end
  end

  pbu_operand_stage u_operand (
    .clk    (clk),
    .en     (en),
    .mode   (mode),
    .top    (top),
    .bottom (bottom),
    .x      (x1),
    .y      (y1),
    .dbl    (dbl1),
    .ctl    (ctl1)
  );

  pbu_product_stage u_product (
    .clk     (clk),
    .en      (en),
    .x       (x1),
    .y       (y1),
    .dbl     (dbl1),
    .ctl_in  (ctl1),
    .sum     (sum2),
    .ctl_out (ctl2)
  );

  pbu_div255_stage u_div255 (
    .clk     (clk),
    .en      (en),
    .sum     (sum2),
    .ctl_in  (ctl2),
    .quo     (quo3),
    .ctl_out (ctl3)
  );

  // Result select; wraps to 8 bits like the overlay arithmetic does
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      sub3[c] = ctl3[c].sub;
      inv3[c] = ctl3[c].inv;
      if (ctl3[c].sub) begin
        res_next[c] = ctl3[c].diff;
      end else if (ctl3[c].inv) begin
        res_next[c] = ~quo3[c][PIX_W-1:0];
      end else begin
        res_next[c] = quo3[c][PIX_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= res_next;
    end
  end

  // Checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_empty_pipe_stays_empty: assert property (@(posedge clk) disable iff (rst)
    (!v1 && !v2 && !v3 && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("output valid with no item in flight");

  a_sub_not_inverted: assert property (@(posedge clk) disable iff (rst)
    v3 |-> ((sub3 & inv3) == '0))
    else $error("subtract and invert both set");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(v3) && $stable(quo3)))
    else $error("pipe moved during stall");

endmodule

`default_nettype wire

// ===== hw/rtl/pbu_operand_stage.sv =====
// ----------------------------------------------------------------------------
// pbu_operand_stage
// Stage 1: picks the multiplier operands, doubling flag and result control.
// ----------------------------------------------------------------------------
`default_nettype none

module pbu_operand_stage
  import pbu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire blend_mode_t mode,
  input  wire pix_vec_t    top,
  input  wire pix_vec_t    bottom,
  output pix_vec_t         x,
  output pix_vec_t         y,
  output logic             dbl,
  output ctl_vec_t         ctl
);

  logic     inv_next;
  logic     dbl_next;
  pix_vec_t x_next;
  pix_vec_t y_next;
  ctl_vec_t ctl_next;

  // Mode decode; overlay branch follows bottom red for all channels
  always_comb begin
    inv_next = 1'b0;
    dbl_next = 1'b0;
    case (mode)
      MODE_MULTIPLY: inv_next = 1'b0;
      MODE_SUBTRACT: inv_next = 1'b0;
      MODE_SCREEN:   inv_next = 1'b1;
      MODE_OVERLAY: begin
        dbl_next = 1'b1;
        inv_next = bottom[0][PIX_W-1];
      end
      default:       inv_next = 1'b0;
    endcase
  end

  // Per-channel operands; 255 - v is the bitwise complement
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      x_next[c]        = inv_next ? ~top[c] : top[c];
      y_next[c]        = inv_next ? ~bottom[c] : bottom[c];
      ctl_next[c].sub  = (mode == MODE_SUBTRACT);
      ctl_next[c].inv  = inv_next;
      ctl_next[c].diff = (bottom[c] > top[c]) ? (bottom[c] - top[c]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x   <= x_next;
      y   <= y_next;
      dbl <= dbl_next;
      ctl <= ctl_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pbu_product_stage.sv =====
// ----------------------------------------------------------------------------
// pbu_product_stage
// Stage 2: 8x8 product per channel, optional doubling, plus rounding bias.
// ----------------------------------------------------------------------------
`default_nettype none

module pbu_product_stage
  import pbu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     en,
  input  wire pix_vec_t x,
  input  wire pix_vec_t y,
  input  wire logic     dbl,
  input  wire ctl_vec_t ctl_in,
  output sum_vec_t      sum,
  output ctl_vec_t      ctl_out
);

  logic [NUM_CHAN-1:0][2*PIX_W-1:0] prod;
  sum_vec_t                         sum_next;

  // Product, doubled in overlay, then biased for round-to-nearest
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      prod[c]     = {{PIX_W{1'b0}}, x[c]} * {{PIX_W{1'b0}}, y[c]};
      sum_next[c] = (dbl ? {prod[c], 1'b0} : {1'b0, prod[c]}) + ROUND_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum     <= sum_next;
      ctl_out <= ctl_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pbu_div255_stage.sv =====
// ----------------------------------------------------------------------------
// pbu_div255_stage
// Stage 3: divide by 255 through a reciprocal multiply and shift.
// ----------------------------------------------------------------------------
`default_nettype none

module pbu_div255_stage
  import pbu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     en,
  input  wire sum_vec_t sum,
  input  wire ctl_vec_t ctl_in,
  output quo_vec_t      quo,
  output ctl_vec_t      ctl_out
);

  logic [NUM_CHAN-1:0][PROD_W-1:0] recip_prod;
  quo_vec_t                        quo_next;

  // Exact over the whole biased range, quotient at most 510
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      recip_prod[c] = PROD_W'(sum[c]) * PROD_W'(RECIP_MULT);
      quo_next[c]   = recip_prod[c][RECIP_SHIFT +: QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo     <= quo_next;
      ctl_out <= ctl_in;
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream check of the RGB pixel blend unit in all four blend modes.
// A scoreboard computes every blended pixel from the live mode register and
// matches each output transfer against the oldest pending pixel. The mode is
// changed only with the pipe drained. Input and output idle in several phases,
// including one long output hold-off that backs the pipe up.
// ----------------------------------------------------------------------------

module testbench;
  import pbu_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PIPE_SETTLE  = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_PIXELS = 119;
  localparam int NUM_PHASES   = 8;

  // Scoreboard: blended pixels still owed by the block
  class pixel_blend_checker;
    pix_vec_t    expected_pixels[$];
    blend_mode_t mode;
    int          errors;

    function new();
      mode   = MODE_MULTIPLY;
      errors = 0;
    endfunction

    // round(x / 255), never a tie
    function int unsigned div255(input int unsigned x);
      return (x + 127) / 255;
    endfunction

    function logic [PIX_W-1:0] blend_chan(input int unsigned a, input int unsigned b,
                                          input bit low_branch);
      int unsigned q;
      case (mode)
        MODE_MULTIPLY: q = div255(a * b);
        MODE_SUBTRACT: q = (b > a) ? b - a : 0;
        MODE_SCREEN:   q = 255 - div255((255 - a) * (255 - b));
        default: begin
          if (low_branch) q = div255(2 * a * b);
          else            q = 255 - div255(2 * (255 - a) * (255 - b));
        end
      endcase
      return q[PIX_W-1:0];
    endfunction

    // Accepted input pair: top in the low half, bottom in the high half
    function void note_pixel(input logic [IN_W-1:0] pair);
      pix_vec_t top, bot, blended;
      top = pair[OUT_W-1:0];
      bot = pair[IN_W-1:OUT_W];
      for (int c = 0; c < NUM_CHAN; c++)
        blended[c] = blend_chan(top[c], bot[c], bot[0] <= 8'd127);
      expected_pixels = {expected_pixels, blended};
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 40) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_pixel(input pix_vec_t got);
      pix_vec_t want;
      string    chan_name[NUM_CHAN];
      chan_name = '{"red", "green", "blue"};
      if (expected_pixels.size() == 0) begin
        report($sformatf("output pixel %h with nothing pending", got));
        return;
      end
      want = expected_pixels.pop_front();
      for (int c = 0; c < NUM_CHAN; c++)
        if (got[c] !== want[c])
          report($sformatf("%s: got %h, want %h (mode %s)", chan_name[c], got[c],
                           want[c], mode.name()));
    endtask

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_data = '0;

  int                tx_idle_pct = 0;
  int                rx_stall_pct = 0;
  int unsigned       hold_req = 0;
  int unsigned       hold_ack = 0;
  int                hold_left = 0;
  int                cycle_count = 0;

  pixel_blend_checker blend_chk = new();

  rgb_pixel_blend_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Output side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Transfer monitors
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) blend_chk.mode = blend_mode_t'(cfg_data);
      if (s_axis_tvalid && s_axis_tready) blend_chk.note_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) blend_chk.check_pixel(m_axis_tdata);
    end
  end

  task automatic send_pixel(input logic [IN_W-1:0] pair);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pair;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_drain();
    while (blend_chk.pending() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input blend_mode_t m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random pair with a bias toward the overlay threshold, top equal to bottom
  // and all-zero / all-one fields
  function automatic logic [IN_W-1:0] random_pair();
    logic [IN_W-1:0] pair;
    int              pick;
    pair = IN_W'({$urandom(), $urandom()});
    pick = $urandom_range(0, 9);
    if (pick == 0) pair[31:24] = 8'($urandom_range(127, 128));
    else if (pick == 1) pair[IN_W-1:OUT_W] = pair[OUT_W-1:0];
    else if (pick == 2)
      for (int f = 0; f < 2 * NUM_CHAN; f++)
        pair[f*PIX_W +: PIX_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return pair;
  endfunction

  initial begin
    // {bottom b,g,r, top b,g,r}
    logic [IN_W-1:0] corner_pairs[6];
    blend_mode_t     dir_modes[4];
    blend_mode_t     rand_modes[NUM_PHASES];
    int              waited;

    corner_pairs = '{
      48'h000000_000000,   // all zero
      48'hFFFFFF_FFFFFF,   // all full scale
      48'h7F00FF_80FF00,   // opposite extremes, overlay high branch
      48'h20FF7F_1000FF,   // bottom red at the overlay threshold
      48'h008080_FFC040,   // bottom red just above the threshold
      48'h33AA55_33AA55    // top equals bottom
    };
    dir_modes  = '{MODE_MULTIPLY, MODE_SUBTRACT, MODE_SCREEN, MODE_OVERLAY};
    rand_modes = '{MODE_MULTIPLY, MODE_OVERLAY, MODE_SUBTRACT, MODE_SCREEN,
                   MODE_OVERLAY, MODE_SCREEN, MODE_MULTIPLY, MODE_SUBTRACT};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners; multiply first runs on the reset mode
    foreach (dir_modes[m]) begin
      if (m != 0) write_mode(dir_modes[m]);
      foreach (corner_pairs[i]) send_pixel(corner_pairs[i]);
      s_axis_tvalid <= 1'b0;
      wait_drain();
    end

    // Random phases, cycling through the idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_mode(rand_modes[p]);
      tx_idle_pct  = ((p % 4) == 1) ? 73 : ((p % 4) == 3) ? 12 : 0;
      rx_stall_pct <= ((p % 4) == 2) ? 73 : ((p % 4) == 3) ? 12 : 0;
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (p == 0 && i == 40) hold_req <= hold_req + 1;
        if (p == 1 && i == 60) begin
          s_axis_tvalid <= 1'b0;
          wait_drain();
        end
        send_pixel(random_pair());
      end
      s_axis_tvalid <= 1'b0;
      wait_drain();
    end

    // Final drain, bounded
    waited = 0;
    while (blend_chk.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_SETTLE) @(posedge clk);
    if (blend_chk.pending() != 0)
      blend_chk.report($sformatf("%0d pixels never came out", blend_chk.pending()));

    if (blend_chk.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
